FILE: sv/dibpu_pkg.sv
// Shared types and codes for the DIB pixel unpacker.
// Holds the opcode, format, register and job-mode codes and the job/result records.
// Depends on nothing.
package dibpu_pkg;

	localparam int MAX_WIDTH_DEF     = 256;
	localparam int PALETTE_DEPTH_DEF = 256;

	localparam logic [1:0] OP_PAL_WR = 2'd0;
	localparam logic [1:0] OP_PIXEL  = 2'd1;
	localparam logic [1:0] OP_MASK   = 2'd2;

	localparam logic [2:0] FMT_1BPP   = 3'd0;
	localparam logic [2:0] FMT_4BPP   = 3'd1;
	localparam logic [2:0] FMT_8BPP   = 3'd2;
	localparam logic [2:0] FMT_555    = 3'd3;
	localparam logic [2:0] FMT_565    = 3'd4;
	localparam logic [2:0] FMT_24BPP  = 3'd5;
	localparam logic [2:0] FMT_32BPP  = 3'd6;
	localparam logic [2:0] FMT_UNUSED = 3'd7;

	localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam logic KIND_COLOR = 1'b0;
	localparam logic KIND_ALPHA = 1'b1;

	localparam logic [2:0] MODE_PAL1   = 3'd0;
	localparam logic [2:0] MODE_PAL4   = 3'd1;
	localparam logic [2:0] MODE_PAL8   = 3'd2;
	localparam logic [2:0] MODE_DIRECT = 3'd3;
	localparam logic [2:0] MODE_MASK   = 3'd4;

	typedef struct packed {
		logic        wr;
		logic        kind;
		logic [2:0]  mode;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [3:0]  cnt;
		logic [7:0]  data;
		logic [7:0]  pal_idx;
		logic [23:0] pal_rgb;
		logic [31:0] rgba;
	} job_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [31:0] rgba;
		logic        last;
	} res_t;

endpackage

FILE: sv/dib_pixel_unpack_to_bgra.sv
// Top level of the DIB pixel unpacker: configuration registers, decode and palette lookup.
// Depends on dibpu_pkg, dibpu_decode and dibpu_lookup.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one transaction per palette entry write,
//   pixel data byte or mask data byte. Output channel (out_valid/out_ready) gives one
//   pixel or alpha update per transaction; last marks the final result of an input.
//   Configuration: write pixel_format, image_width, image_height through cfg_we,
//   cfg_index and cfg_data while the block is idle.
//   The first result of an input passes through the job register, the stage-two register
//   and the output register after the input transaction is accepted.
//   Throughput: one result per cycle while out_ready is high, set by the single palette
//   read port; the n results of an input (up to 8 for 1 bpp and mask bytes) are issued
//   one after another. A palette write or a byte with no result gives no output.
//   Reset clears the configuration to 32 bpp, 32 x 32, and all byte and row counters.
//   The palette memory is not cleared; entries are valid once written.
//   When out_ready is low the output register holds its result, the pipeline behind it
//   fills and then in_ready drops until results drain.
module dib_pixel_unpack_to_bgra #(
	parameter int MAX_WIDTH     = dibpu_pkg::MAX_WIDTH_DEF,
	parameter int PALETTE_DEPTH = dibpu_pkg::PALETTE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] palette_index,
	input  logic [7:0] palette_first,
	input  logic [7:0] palette_second,
	input  logic [7:0] palette_third,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic [7:0] column,
	output logic [7:0] row,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [7:0] alpha,
	output logic       last
);
	import dibpu_pkg::*;

	logic [2:0] pixel_format_q;
	logic [8:0] image_width_q;
	logic [8:0] image_height_q;
	logic       job_valid, job_ready;
	job_t       job;
	res_t       out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FMT_32BPP;
			image_width_q  <= 9'd32;
			image_height_q <= 9'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIXEL_FORMAT: pixel_format_q <= cfg_data[2:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dibpu_decode #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.palette_index (palette_index),
		.palette_first (palette_first),
		.palette_second(palette_second),
		.palette_third (palette_third),
		.data_byte     (data_byte),
		.pixel_format  (pixel_format_q),
		.image_width   (image_width_q),
		.image_height  (image_height_q),
		.job_valid     (job_valid),
		.job           (job),
		.job_ready     (job_ready)
	);

	dibpu_lookup #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job      (job),
		.job_ready(job_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (out_res)
	);

	assign kind   = out_res.kind;
	assign column = out_res.col;
	assign row    = out_res.row;
	assign red    = out_res.rgba[31:24];
	assign green  = out_res.rgba[23:16];
	assign blue   = out_res.rgba[15:8];
	assign alpha  = out_res.rgba[7:0];
	assign last   = out_res.last;

endmodule

FILE: sv/dibpu_decode.sv
// Input decode for the DIB pixel unpacker: row/mask byte positions, row counters, partial pixel.
// Turns each input transaction that writes the palette or has a result into one job for the lookup stage.
// Depends on dibpu_pkg.
module dibpu_decode #(
	parameter int MAX_WIDTH = dibpu_pkg::MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [7:0]        palette_index,
	input  logic [7:0]        palette_first,
	input  logic [7:0]        palette_second,
	input  logic [7:0]        palette_third,
	input  logic [7:0]        data_byte,
	input  logic [2:0]        pixel_format,
	input  logic [8:0]        image_width,
	input  logic [8:0]        image_height,
	output logic              job_valid,
	output dibpu_pkg::job_t   job,
	input  logic              job_ready
);
	import dibpu_pkg::*;

	localparam int EFF_MAX = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
	localparam int POS_W   = $clog2(EFF_MAX * 4 + 1);
	localparam int BASE_W  = POS_W + 3;
	localparam int CW      = (BASE_W > 9) ? BASE_W + 1 : 10;
	localparam int DIV_S   = POS_W + 1;
	localparam int DIV_K   = (1 << DIV_S) / 3;
	localparam int PROD_W  = POS_W + DIV_S;

	logic [POS_W-1:0]  rbp_q, mbp_q;
	logic [7:0]        prc_q, mrc_q;
	logic [23:0]       part_q, part_d;

	logic [8:0]        w, h;
	logic [13:0]       bits;
	logic [14:0]       bsum;
	logic [9:0]        msum;
	logic [POS_W-1:0]  pstride, mstride;
	logic [POS_W-1:0]  p, mp, p_next, mp_next;
	logic [7:0]        r, mr;
	logic [8:0]        r_inc, mr_inc;
	logic [7:0]        prow, mrow;
	logic [CW-1:0]     base1, base4, base8, mbase, wl, lim2, lim3, lim4;
	logic [PROD_W-1:0] dprod;
	logic [POS_W-1:0]  q0, r0, q3, q4;
	logic [1:0]        k3, k4;
	logic              make, pix_step, mask_step;

	function automatic logic [3:0] fit_count(input logic [CW-1:0] base,
		input logic [CW-1:0] lim, input logic [3:0] most);
		logic [CW-1:0] rem;
		rem = lim - base;
		if (base >= lim)
			return 4'd0;
		if (rem > CW'(most))
			return most;
		return rem[3:0];
	endfunction

	always_comb begin
		w = image_width;
		if (image_width == 9'd0)
			w = 9'd1;
		else if (image_width > 9'(EFF_MAX))
			w = 9'(EFF_MAX);
		h = image_height;
		if (image_height == 9'd0)
			h = 9'd1;
		else if (image_height > 9'd256)
			h = 9'd256;
	end

	always_comb begin
		unique case (pixel_format)
			FMT_1BPP: bits = {5'd0, w};
			FMT_4BPP: bits = {3'd0, w, 2'd0};
			FMT_8BPP: bits = {2'd0, w, 3'd0};
			FMT_555, FMT_565: bits = {1'b0, w, 4'd0};
			FMT_24BPP: bits = {1'b0, w, 4'd0} + {2'd0, w, 3'd0};
			default: bits = {w, 5'd0};
		endcase
	end

	assign bsum    = {1'b0, bits} + 15'd31;
	assign pstride = POS_W'({bsum[14:5], 2'b00});
	assign msum    = {1'b0, w} + 10'd31;
	assign mstride = POS_W'({msum[9:5], 2'b00});

	assign p       = (rbp_q >= pstride) ? '0 : rbp_q;
	assign mp      = (mbp_q >= mstride) ? '0 : mbp_q;
	assign r       = ({1'b0, prc_q} >= h) ? 8'd0 : prc_q;
	assign mr      = ({1'b0, mrc_q} >= h) ? 8'd0 : mrc_q;
	assign prow    = 8'(h - 9'd1 - {1'b0, r});
	assign mrow    = 8'(h - 9'd1 - {1'b0, mr});
	assign p_next  = p + 1'b1;
	assign mp_next = mp + 1'b1;
	assign r_inc   = {1'b0, r} + 9'd1;
	assign mr_inc  = {1'b0, mr} + 9'd1;

	assign base1 = CW'({p, 3'b000});
	assign base4 = CW'({p, 1'b0});
	assign base8 = CW'(p);
	assign mbase = CW'({mp, 3'b000});
	assign wl    = CW'(w);
	assign lim2  = CW'({w, 1'b0});
	assign lim3  = CW'({w, 1'b0}) + CW'(w);
	assign lim4  = CW'({w, 2'b00});

	// divide the byte position by three: reciprocal product, then one correction
	assign dprod = PROD_W'(p) * PROD_W'(DIV_K);
	assign q0    = dprod[PROD_W-1:DIV_S];
	assign r0    = p - (q0 + (q0 << 1));
	always_comb begin
		if (r0 >= POS_W'(3)) begin
			q3 = q0 + 1'b1;
			k3 = 2'(r0 - POS_W'(3));
		end else begin
			q3 = q0;
			k3 = r0[1:0];
		end
	end
	assign q4 = p >> 2;
	assign k4 = p[1:0];

	always_comb begin
		job         = '0;
		part_d      = part_q;
		job.data    = data_byte;
		job.pal_idx = palette_index;
		job.pal_rgb = {palette_first, palette_second, palette_third};
		job.row     = prow;
		job.kind    = KIND_COLOR;
		unique case (opcode)
			OP_PAL_WR: begin
				job.wr = 1'b1;
			end
			OP_PIXEL: begin
				unique case (pixel_format)
					FMT_1BPP: begin
						job.mode = MODE_PAL1;
						job.col  = base1[7:0];
						job.cnt  = fit_count(base1, wl, 4'd8);
					end
					FMT_4BPP: begin
						job.mode = MODE_PAL4;
						job.col  = base4[7:0];
						job.cnt  = fit_count(base4, wl, 4'd2);
					end
					FMT_8BPP: begin
						job.mode = MODE_PAL8;
						job.col  = base8[7:0];
						job.cnt  = fit_count(base8, wl, 4'd1);
					end
					FMT_555, FMT_565: begin
						job.mode = MODE_DIRECT;
						job.col  = 8'(p >> 1);
						if (CW'(p) < lim2) begin
							if (!p[0]) begin
								part_d = {16'd0, data_byte};
							end else begin
								job.cnt = 4'd1;
								if (pixel_format == FMT_555)
									job.rgba = {data_byte[6:2], data_byte[6:4],
										data_byte[1:0], part_q[7:5], data_byte[1:0], part_q[7],
										part_q[4:0], part_q[4:2], 8'hff};
								else
									job.rgba = {data_byte[7:3], data_byte[7:5],
										data_byte[2:0], part_q[7:5], data_byte[2:1],
										part_q[4:0], part_q[4:2], 8'hff};
							end
						end
					end
					FMT_24BPP: begin
						job.mode = MODE_DIRECT;
						job.col  = 8'(q3);
						if (CW'(p) < lim3) begin
							unique case (k3)
								2'd0: part_d = {16'd0, data_byte};
								2'd1: part_d = part_q | {8'd0, data_byte, 8'd0};
								default: begin
									job.cnt  = 4'd1;
									job.rgba = {part_q[7:0], part_q[15:8], data_byte, 8'hff};
								end
							endcase
						end
					end
					FMT_32BPP: begin
						job.mode = MODE_DIRECT;
						job.col  = 8'(q4);
						if (CW'(p) < lim4) begin
							unique case (k4)
								2'd0: part_d = {16'd0, data_byte};
								2'd1: part_d = part_q | {8'd0, data_byte, 8'd0};
								2'd2: part_d = part_q | {data_byte, 16'd0};
								default: begin
									job.cnt  = 4'd1;
									job.rgba = {part_q[7:0], part_q[15:8], part_q[23:16],
										data_byte};
								end
							endcase
						end
					end
					default: ;
				endcase
			end
			OP_MASK: begin
				if (pixel_format != FMT_32BPP && pixel_format != FMT_UNUSED) begin
					job.mode = MODE_MASK;
					job.kind = KIND_ALPHA;
					job.row  = mrow;
					job.col  = mbase[7:0];
					job.cnt  = fit_count(mbase, wl, 4'd8);
				end
			end
			default: ;
		endcase
	end

	assign make      = job.wr || (job.cnt != 4'd0);
	assign job_valid = in_valid && make;
	assign in_ready  = job_ready;
	assign pix_step  = (opcode == OP_PIXEL) && (pixel_format != FMT_UNUSED);
	assign mask_step = (opcode == OP_MASK) && (pixel_format != FMT_32BPP)
		&& (pixel_format != FMT_UNUSED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rbp_q  <= '0;
			mbp_q  <= '0;
			prc_q  <= 8'd0;
			mrc_q  <= 8'd0;
			part_q <= 24'd0;
		end else if (in_valid && in_ready) begin
			if (pix_step) begin
				part_q <= part_d;
				if (p_next >= pstride) begin
					rbp_q <= '0;
					prc_q <= (r_inc >= h) ? 8'd0 : r_inc[7:0];
				end else begin
					rbp_q <= p_next;
					prc_q <= r;
				end
			end
			if (mask_step) begin
				if (mp_next >= mstride) begin
					mbp_q <= '0;
					mrc_q <= (mr_inc >= h) ? 8'd0 : mr_inc[7:0];
				end else begin
					mbp_q <= mp_next;
					mrc_q <= mr;
				end
			end
		end
	end

endmodule

FILE: sv/dibpu_lookup.sv
// Palette memory and result pipeline for the DIB pixel unpacker.
// Issues job results one a cycle unless stalled, reads palette, drives the output register.
// Depends on dibpu_pkg.
module dibpu_lookup #(
	parameter int PALETTE_DEPTH = dibpu_pkg::PALETTE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  dibpu_pkg::job_t   job,
	output logic              job_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output dibpu_pkg::res_t   out_res
);
	import dibpu_pkg::*;

	localparam int PAL_AW = $clog2(PALETTE_DEPTH);

	logic [23:0] pal_mem [PALETTE_DEPTH];
	logic [23:0] rd_q;

	job_t        job_q;
	logic        job_v_q;
	logic [2:0]  i_q;
	logic        s2_v_q, pal_s2, inr_s2;
	res_t        res_s2, res_i, res_o, out_q;
	logic        out_v_q;

	logic        last_i, issue_go, wr_go, job_done, s2_free, s2_adv;
	logic        bit_sel, use_pal, inr_i;
	logic [7:0]  idx;

	assign last_i   = ({1'b0, i_q} == (job_q.cnt - 4'd1));
	assign s2_adv   = !out_v_q || out_ready;
	assign s2_free  = !s2_v_q || s2_adv;
	assign issue_go = job_v_q && !job_q.wr && s2_free;
	assign wr_go    = job_v_q && job_q.wr && ({1'b0, job_q.pal_idx} < 9'(PALETTE_DEPTH));
	assign job_done = job_v_q && (job_q.wr || (issue_go && last_i));
	assign job_ready = !job_v_q || job_done;

	assign bit_sel = job_q.data[3'd7 - i_q];
	assign use_pal = (job_q.mode == MODE_PAL1) || (job_q.mode == MODE_PAL4)
		|| (job_q.mode == MODE_PAL8);
	assign inr_i   = ({1'b0, idx} < 9'(PALETTE_DEPTH));

	always_comb begin
		unique case (job_q.mode)
			MODE_PAL1: idx = {7'd0, bit_sel};
			MODE_PAL4: idx = (i_q == 3'd0) ? {4'd0, job_q.data[7:4]} : {4'd0, job_q.data[3:0]};
			MODE_PAL8: idx = job_q.data;
			default:   idx = 8'd0;
		endcase
	end

	always_comb begin
		res_i.kind = job_q.kind;
		res_i.col  = job_q.col + {5'd0, i_q};
		res_i.row  = job_q.row;
		res_i.last = last_i;
		if (job_q.mode == MODE_MASK)
			res_i.rgba = {24'd0, bit_sel ? 8'h00 : 8'hff};
		else if (use_pal)
			res_i.rgba = {24'd0, 8'hff};
		else
			res_i.rgba = job_q.rgba;
	end

	always_comb begin
		res_o = res_s2;
		if (pal_s2)
			res_o.rgba[31:8] = inr_s2 ? rd_q : 24'd0;
	end

	always_ff @(posedge clk) begin
		if (wr_go)
			pal_mem[job_q.pal_idx[PAL_AW-1:0]] <= job_q.pal_rgb;
		if (issue_go)
			rd_q <= pal_mem[idx[PAL_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q <= 1'b0;
			i_q     <= 3'd0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (job_ready)
				job_v_q <= job_valid;
			if (issue_go)
				i_q <= last_i ? 3'd0 : i_q + 3'd1;
			if (s2_free)
				s2_v_q <= issue_go;
			if (s2_adv)
				out_v_q <= s2_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid)
			job_q <= job;
		if (issue_go) begin
			res_s2 <= res_i;
			pal_s2 <= use_pal;
			inr_s2 <= inr_i;
		end
		if (s2_adv && s2_v_q)
			out_q <= res_o;
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;

endmodule

FILE: sv/dibpu_checker.sv
// Port-level checks for the DIB pixel unpacker, with the bind that attaches them.
// Depends on dibpu_pkg and dib_pixel_unpack_to_bgra.
module dibpu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       kind,
	input logic [7:0] column,
	input logic [7:0] row,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic [7:0] alpha,
	input logic       last
);
	import dibpu_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(column) && $stable(row)
			&& $stable(alpha) && $stable(last))
		else $error("output transaction changed while stalled");

	a_mask_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ALPHA |-> red == 8'd0 && green == 8'd0 && blue == 8'd0
			&& (alpha == 8'h00 || alpha == 8'hff))
		else $error("alpha update carries colour or a partial alpha");

	a_burst_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside the results of one input");

	a_burst_walk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> row == $past(row) && kind == $past(kind)
			&& column == $past(column) + 8'd1)
		else $error("results of one input do not walk along one row");

endmodule

bind dib_pixel_unpack_to_bgra dibpu_checker u_dibpu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.kind     (kind),
	.column   (column),
	.row      (row),
	.red      (red),
	.green    (green),
	.blue     (blue),
	.alpha    (alpha),
	.last     (last)
);
